FILE: rtl/mspr_pkg.sv
// Shared types and constants for the ranged minimal-standard generator.
// No dependencies; imported by every module under rtl/.
package mspr_pkg;

   localparam int unsigned WORD_W = 31;               // generator word and bound width
   localparam int unsigned SPAN_W = WORD_W + 1;       // span reaches 2^31
   localparam int unsigned MULT_W = 15;               // width of the 16807 multiplier
   localparam int unsigned PROD_W = WORD_W + MULT_W;  // full product width
   localparam int unsigned CNT_W  = $clog2(WORD_W);   // remainder step counter

   localparam logic [WORD_W-1:0] PM_MODULUS = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0] PM_MULT    = 15'd16807;
   localparam logic [WORD_W-1:0] SEED_RESET = 31'd1;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MULT,
      BK_FOLD,
      BK_DIVIDE,
      BK_FINISH
   } mspr_state_type;

   // One classified request: equal bounds, or an ordered low bound and span.
   typedef struct packed {
      logic              equal;
      logic [WORD_W-1:0] low;
      logic [SPAN_W-1:0] span;
   } mspr_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mspr_qstat_type;

endpackage

FILE: rtl/mspr_front.sv
// Request classifier: orders the two bounds, flags equal bounds, forms the span.
// Depends on mspr_pkg; feeds mspr_queue.
module mspr_front (
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mspr_pkg::WORD_W-1:0]    req_bound_a,
   input  logic [mspr_pkg::WORD_W-1:0]    req_bound_b,
   input  mspr_pkg::mspr_qstat_type       qstat,
   output logic                           push,
   output mspr_pkg::mspr_entry_type       push_entry
);
   import mspr_pkg::*;

   logic              swap;
   logic [WORD_W-1:0] low;
   logic [WORD_W-1:0] high;

   always_comb begin
      swap = $signed(req_bound_a) > $signed(req_bound_b);
      low  = swap ? req_bound_b : req_bound_a;
      high = swap ? req_bound_a : req_bound_b;

      push_entry.equal = (req_bound_a == req_bound_b);
      push_entry.low   = low;
      // sign-extend both ends; the difference plus one is always positive
      push_entry.span  = {high[WORD_W-1], high} - {low[WORD_W-1], low} + SPAN_W'(1);

      req_stall = qstat.full;
      push      = req_valid && !qstat.full;
   end

endmodule

FILE: rtl/mspr_queue.sv
// Small register queue between the classifier and the draw engine.
// Depends on mspr_pkg for the entry and status types.
module mspr_queue #(
   parameter int unsigned Depth = mspr_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mspr_pkg::mspr_entry_type  push_entry,
   input  logic                      pop,
   output mspr_pkg::mspr_entry_type  head,
   output mspr_pkg::mspr_qstat_type  qstat
);
   import mspr_pkg::*;

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   mspr_entry_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end

      head        = entries_ff[rd_ptr_ff];
      qstat.full  = (count_ff == CntW'(Depth));
      qstat.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/mspr_back.sv
// Draw engine: holds the generator word, advances it, reduces it modulo the
// span one bit per cycle and drives the result register. Depends on mspr_pkg.
module mspr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  mspr_pkg::mspr_entry_type     head,
   input  mspr_pkg::mspr_qstat_type     qstat,
   output logic                         pop,
   input  logic                         csr_wr_en,
   input  logic [mspr_pkg::WORD_W-1:0]  csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mspr_pkg::WORD_W-1:0]  rsp_value,
   output logic [mspr_pkg::WORD_W-1:0]  rsp_generator_word
);
   import mspr_pkg::*;

   mspr_state_type    fsm_ff,       fsm_in;
   logic [WORD_W-1:0] word_ff,      word_in;
   logic [PROD_W-1:0] prod_ff,      prod_in;
   logic [WORD_W-1:0] div_ff,       div_in;
   logic [WORD_W-1:0] rem_ff,       rem_in;
   logic [CNT_W-1:0]  cnt_ff,       cnt_in;
   logic [WORD_W-1:0] low_ff,       low_in;
   logic [SPAN_W-1:0] span_ff,      span_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [WORD_W-1:0] rsp_word_ff,  rsp_word_in;

   logic              slot_free;
   logic [SPAN_W-1:0] fold_sum;
   logic [SPAN_W-1:0] fold_red;
   logic [WORD_W-1:0] next_word;
   logic [SPAN_W-1:0] shifted;
   logic [WORD_W-1:0] rem_next;

   always_comb begin
      // 16807*x mod (2^31-1): fold the high product bits onto the low ones
      fold_sum  = SPAN_W'(prod_ff[PROD_W-1:WORD_W]) + {1'b0, prod_ff[WORD_W-1:0]};
      fold_red  = (fold_sum >= {1'b0, PM_MODULUS}) ? fold_sum - {1'b0, PM_MODULUS}
                                                  : fold_sum;
      // a zero residue maps to the modulus
      next_word = (fold_red[WORD_W-1:0] == '0) ? PM_MODULUS : fold_red[WORD_W-1:0];

      // restoring remainder step: bring down one dividend bit
      shifted  = {rem_ff, div_ff[WORD_W-1]};
      rem_next = (shifted >= span_ff) ? WORD_W'(shifted - span_ff) : shifted[WORD_W-1:0];
   end

   always_comb begin
      fsm_in       = fsm_ff;
      word_in      = word_ff;
      prod_in      = prod_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      rsp_value_in = rsp_value_ff;
      rsp_word_in  = rsp_word_ff;
      pop          = 1'b0;
      slot_free    = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (fsm_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               if (head.equal) begin
                  if (slot_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = head.low;
                     rsp_word_in  = word_ff;
                  end
               end else begin
                  pop     = 1'b1;
                  low_in  = head.low;
                  span_in = head.span;
                  fsm_in  = BK_MULT;
               end
            end
         end
         BK_MULT: begin
            prod_in = PROD_W'(word_ff) * PROD_W'(PM_MULT);
            fsm_in  = BK_FOLD;
         end
         BK_FOLD: begin
            word_in = next_word;
            div_in  = next_word;
            rem_in  = '0;
            cnt_in  = CNT_W'(WORD_W - 1);
            fsm_in  = BK_DIVIDE;
         end
         BK_DIVIDE: begin
            rem_in = rem_next;
            div_in = {div_ff[WORD_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               fsm_in = BK_FINISH;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         BK_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rem_ff + low_ff;
               rsp_word_in  = word_ff;
               fsm_in       = BK_IDLE;
            end
         end
         default: begin
            fsm_in = BK_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         word_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= BK_IDLE;
         word_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      low_ff       <= low_in;
      span_ff      <= span_in;
      rsp_value_ff <= rsp_value_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_generator_word = rsp_word_ff;

endmodule

FILE: rtl/minimal_standard_prng_ranged.sv
// Ranged draws from the minimal-standard generator (x' = 16807*x mod 2^31-1).
// Each request carries two signed 31-bit bounds in either order. When the
// bounds are equal the response is that bound and the generator word is
// returned unchanged. Otherwise the word advances one step (a product
// state, then a fold state), the new word is reduced modulo the span
// high-low+1 by a radix-2 restoring remainder loop that handles one bit
// per cycle, and low is added back; the generator word after the step is
// reported alongside the draw. A two-entry request queue lets new requests
// be taken while a draw is in progress, and a result register lets the
// engine finish while the consumer stalls. Writing csr_wr_data with
// csr_wr_en reloads the generator word; after reset the word is 1.
// Depends on mspr_pkg and the mspr_* modules.
module minimal_standard_prng_ranged #(
   parameter int unsigned QueueDepth = mspr_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mspr_pkg::WORD_W-1:0]  req_bound_a,
   input  logic [mspr_pkg::WORD_W-1:0]  req_bound_b,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mspr_pkg::WORD_W-1:0]  rsp_value,
   output logic [mspr_pkg::WORD_W-1:0]  rsp_generator_word,
   // seed register
   input  logic                         csr_wr_en,
   input  logic [mspr_pkg::WORD_W-1:0]  csr_wr_data
);
   import mspr_pkg::*;

   mspr_entry_type push_entry;
   mspr_entry_type head;
   mspr_qstat_type qstat;
   logic           push;
   logic           pop;

   // Order the bounds and compute the span as the request arrives.
   mspr_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_bound_a (req_bound_a),
      .req_bound_b (req_bound_b),
      .qstat       (qstat),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Hold classified requests until the engine is free.
   mspr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // Advance the generator, reduce, and drive the response register.
   mspr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .qstat              (qstat),
      .pop                (pop),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_generator_word (rsp_generator_word)
   );

endmodule
